FILE: rtl/wrtp_pkg.sv
// ----------------------------------------------------------------------------
// wrtp_pkg
// Shared types, sizes and constants of the weighted random tile picker.
// ----------------------------------------------------------------------------
package wrtp_pkg;

    localparam int TILE_COUNT  = 256;
    localparam int MAX_ENTRIES = 8;
    localparam int KEY_BITS    = 16;

    localparam int TILE_BITS  = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
    localparam int ENT_BITS   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LEN_BITS   = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_BITS   = 16 + LEN_BITS;
    localparam int ADDR_BITS  = TILE_BITS + ENT_BITS;
    localparam int DEPTH      = TILE_COUNT * MAX_ENTRIES;
    localparam int ENTRY_BITS = KEY_BITS + 16;
    localparam int LIST_BITS  = LEN_BITS + SUM_BITS;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_UPDATE = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_PICK   = 3'd3,
        ACT_CLEAR  = 3'd4,
        ACT_COUNT  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        REG_SEED     = 2'd0,
        REG_FALLBACK = 2'd1
    } reg_index_t;

endpackage

FILE: rtl/wrtp_ram.sv
// ----------------------------------------------------------------------------
// wrtp_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wrtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/wrtp_mod.sv
// ----------------------------------------------------------------------------
// wrtp_mod
// Restoring divider remainder: 32-bit value modulo a SUM_BITS divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrtp_mod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [31:0]                   dividend,
    input  logic [wrtp_pkg::SUM_BITS-1:0] divisor,
    output logic                          done,
    output logic [wrtp_pkg::SUM_BITS-1:0] remainder
);
    localparam int SB = wrtp_pkg::SUM_BITS;

    logic [31:0] num_reg;
    logic [SB:0] rem_reg;
    logic [SB-1:0] div_reg;
    logic [5:0] cnt_reg;
    logic busy_reg;
    logic [SB:0] shifted;
    logic [SB:0] diff;

    assign shifted = {rem_reg[SB-1:0], num_reg[31]};
    assign diff    = shifted - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
                num_reg  <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
            end else if (busy_reg) begin
                num_reg <= {num_reg[30:0], 1'b0};
                rem_reg <= diff[SB] ? shifted : diff;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign remainder = rem_reg[SB-1:0];
endmodule

FILE: rtl/weighted_random_tile_picker_unit.sv
// ----------------------------------------------------------------------------
// weighted_random_tile_picker_unit
// Per-tile weighted lists of sprite keys with LCG-driven weighted picks.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel (one transaction per request) and each
// gives exactly one result transaction on m_axis. Requests are handled one at
// a time by a sequencer around two memories: an entry RAM holding key and
// weight per list slot, and a list RAM holding length and weight sum per tile.
// Both have registered reads; a change to a list reads it, then writes it back.
// Steps per request: count, clear, unused codes and a pick of an empty list
// finish on the list read; add/update scan the entries, then write; remove
// scans, then moves each later entry down one slot; pick steps the LCG, runs
// the bit-serial modulo, then walks the entries to the picked weight.
// No new request is taken until m_axis has taken the result and out_valid_reg
// has cleared.
// If m_axis stalls, the result holds and no new request is taken.
// Reset (synchronous, aresetn low) zeros the list RAM by a clearing pass over
// every tile; s_axis_tready stays low during it. APB writes are taken at any
// time outside reset; the seed write loads the generator state directly.
// ----------------------------------------------------------------------------
module weighted_random_tile_picker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: action[2:0], tile_id[10:3], sprite_key[26:11], weight[42:27]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: ok[0], picked_key[16:1], entry_total[20:17]
    output logic [23:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int TB = wrtp_pkg::TILE_BITS;
    localparam int EB = wrtp_pkg::ENT_BITS;
    localparam int LB = wrtp_pkg::LEN_BITS;
    localparam int SB = wrtp_pkg::SUM_BITS;
    localparam int KB = wrtp_pkg::KEY_BITS;
    localparam int AB = wrtp_pkg::ADDR_BITS;
    localparam logic [LB-1:0] MAXLEN = LB'(wrtp_pkg::MAX_ENTRIES);

    typedef enum logic [11:0] {
        S_INIT   = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_LREAD  = 12'b000000000100,
        S_SCAN   = 12'b000000001000,
        S_SCANW  = 12'b000000010000,
        S_DECIDE = 12'b000000100000,
        S_SHIFT  = 12'b000001000000,
        S_SHIFTW = 12'b000010000000,
        S_MUL    = 12'b000100000000,
        S_MOD    = 12'b001000000000,
        S_WALK   = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } state_t;

    state_t state_reg;
    logic [31:0] gen_reg, fallback_reg, seed_reg;
    logic [2:0]  act_reg;
    logic [TB-1:0] tile_reg;
    logic [KB-1:0] key_reg;
    logic [15:0] w_reg;
    logic [LB-1:0] len_reg;
    logic [SB-1:0] sum_reg, acc_reg;
    logic [LB-1:0] idx_reg;
    logic found_reg;
    logic [EB-1:0] pos_reg;
    logic [15:0] oldw_reg;
    logic [SB-1:0] r_reg;
    logic [TB:0] init_reg;
    logic out_valid_reg;
    logic [23:0] out_reg;

    // entry RAM
    logic e_we;
    logic [AB-1:0] e_waddr, e_raddr;
    logic [wrtp_pkg::ENTRY_BITS-1:0] e_wdata, e_rdata;
    // list RAM
    logic l_we;
    logic [TB-1:0] l_waddr;
    logic [wrtp_pkg::LIST_BITS-1:0] l_wdata, l_rdata;

    logic [KB-1:0] rd_key;
    logic [15:0] rd_w;
    assign rd_key = e_rdata[KB-1:0];
    assign rd_w   = e_rdata[wrtp_pkg::ENTRY_BITS-1:KB];

    wrtp_ram #(.WIDTH(wrtp_pkg::ENTRY_BITS), .DEPTH(wrtp_pkg::DEPTH)) u_entry (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );
    wrtp_ram #(.WIDTH(wrtp_pkg::LIST_BITS), .DEPTH(wrtp_pkg::TILE_COUNT)) u_list (
        .aclk(aclk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(s_axis_tdata[10:3]), .rdata(l_rdata)
    );

    logic mod_start, mod_done;
    logic [SB-1:0] mod_rem;
    wrtp_mod u_mod (
        .aclk(aclk), .aresetn(aresetn), .start(mod_start), .dividend(gen_reg),
        .divisor(sum_reg), .done(mod_done), .remainder(mod_rem)
    );

    logic in_fire, cfg_wr, seed_wr;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign seed_wr = cfg_wr && (paddr[2] == 1'(wrtp_pkg::REG_SEED));
    assign prdata = paddr[2] ? fallback_reg : seed_reg;

    logic [AB-1:0] base_addr;
    assign base_addr = {tile_reg, {EB{1'b0}}};

    logic [SB-1:0] acc_next;
    assign acc_next = acc_reg + SB'(rd_w);

    always_comb begin
        e_raddr = base_addr | AB'(idx_reg[EB-1:0]);
        if (state_reg == S_IDLE) begin
            e_raddr = {s_axis_tdata[10:3], {EB{1'b0}}};
        end
        // idx_reg is only rewound at the end of this state
        if (state_reg == S_LREAD) begin
            e_raddr = base_addr;
        end
        mod_start = (state_reg == S_MUL);
    end

    task automatic finish(input logic ok, input logic [KB-1:0] pk,
                          input logic [LB-1:0] n);
        out_reg       <= {3'b000, 4'(n), 16'(pk), ok};
        out_valid_reg <= 1'b1;
        state_reg     <= S_IDLE;
    endtask

    always_ff @(posedge aclk) begin
        e_we <= 1'b0;
        l_we <= 1'b0;
        if (cfg_wr && paddr[2] == 1'(wrtp_pkg::REG_FALLBACK)) begin
            fallback_reg <= pwdata;
        end
        if (cfg_wr && paddr[2] == 1'(wrtp_pkg::REG_SEED)) begin
            seed_reg <= pwdata;
        end
        if (!aresetn) begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            out_valid_reg <= 1'b0;
            gen_reg       <= '0;
            fallback_reg  <= 32'd1;
            seed_reg      <= '0;
        end else begin
            if (out_valid_reg && m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (seed_wr) begin
                gen_reg <= pwdata;
            end
            case (state_reg)
                S_INIT: begin
                    // the extra pass with init_reg[TB] set lets the last clearing write land
                    if (init_reg[TB]) begin
                        state_reg <= S_IDLE;
                    end else begin
                        l_we     <= 1'b1;
                        l_waddr  <= init_reg[TB-1:0];
                        l_wdata  <= '0;
                        init_reg <= init_reg + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        act_reg  <= s_axis_tdata[2:0];
                        tile_reg <= s_axis_tdata[10:3];
                        key_reg  <= s_axis_tdata[11 +: KB];
                        w_reg    <= s_axis_tdata[42:27];
                        state_reg <= S_LREAD;
                    end
                end
                S_LREAD: begin
                    len_reg   <= l_rdata[LB-1:0];
                    sum_reg   <= l_rdata[wrtp_pkg::LIST_BITS-1:LB];
                    idx_reg   <= '0;
                    acc_reg   <= '0;
                    found_reg <= 1'b0;
                    case (act_reg)
                        wrtp_pkg::ACT_CLEAR: begin
                            l_we <= 1'b1; l_waddr <= tile_reg; l_wdata <= '0;
                            finish(1'b1, '0, '0);
                        end
                        wrtp_pkg::ACT_COUNT: finish(1'b1, '0, l_rdata[LB-1:0]);
                        wrtp_pkg::ACT_PICK: begin
                            if (l_rdata[LB-1:0] == '0 ||
                                l_rdata[wrtp_pkg::LIST_BITS-1:LB] == '0) begin
                                finish(1'b0, '0, l_rdata[LB-1:0]);
                            end else begin
                                state_reg <= S_MUL;
                                if (gen_reg == '0) begin
                                    gen_reg <= fallback_reg * wrtp_pkg::LCG_MUL
                                               + wrtp_pkg::LCG_ADD;
                                end else begin
                                    gen_reg <= gen_reg * wrtp_pkg::LCG_MUL
                                               + wrtp_pkg::LCG_ADD;
                                end
                            end
                        end
                        wrtp_pkg::ACT_ADD, wrtp_pkg::ACT_UPDATE,
                        wrtp_pkg::ACT_REMOVE: begin
                            if (l_rdata[LB-1:0] == '0) begin
                                state_reg <= S_DECIDE;
                            end else begin
                                state_reg <= S_SCAN;
                            end
                        end
                        default: finish(1'b0, '0, l_rdata[LB-1:0]);
                    endcase
                end
                S_SCAN: begin
                    // e_rdata holds entry idx_reg
                    if (rd_key == key_reg) begin
                        found_reg <= 1'b1;
                        pos_reg   <= idx_reg[EB-1:0];
                        oldw_reg  <= rd_w;
                        state_reg <= S_DECIDE;
                    end else if (idx_reg + 1'b1 >= len_reg) begin
                        state_reg <= S_DECIDE;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SCANW;
                    end
                end
                S_SCANW: state_reg <= S_SCAN;
                S_DECIDE: begin
                    if (act_reg == wrtp_pkg::ACT_REMOVE) begin
                        if (!found_reg) begin
                            finish(1'b0, '0, len_reg);
                        end else begin
                            sum_reg <= sum_reg - SB'(oldw_reg);
                            idx_reg <= LB'(pos_reg) + 1'b1;
                            state_reg <= S_SHIFTW;
                        end
                    end else if (w_reg == '0) begin
                        finish(1'b0, '0, len_reg);
                    end else if (found_reg) begin
                        e_we <= 1'b1;
                        e_waddr <= base_addr | AB'(pos_reg);
                        e_wdata <= {w_reg, key_reg};
                        l_we <= 1'b1; l_waddr <= tile_reg;
                        l_wdata <= {sum_reg - SB'(oldw_reg) + SB'(w_reg), len_reg};
                        finish(1'b1, '0, len_reg);
                    end else if (act_reg == wrtp_pkg::ACT_ADD && len_reg < MAXLEN) begin
                        e_we <= 1'b1;
                        e_waddr <= base_addr | AB'(len_reg[EB-1:0]);
                        e_wdata <= {w_reg, key_reg};
                        l_we <= 1'b1; l_waddr <= tile_reg;
                        l_wdata <= {sum_reg + SB'(w_reg), len_reg + 1'b1};
                        finish(1'b1, '0, len_reg + 1'b1);
                    end else begin
                        finish(1'b0, '0, len_reg);
                    end
                end
                S_SHIFTW: begin
                    // read of idx_reg is issued this cycle
                    if (idx_reg >= len_reg) begin
                        l_we <= 1'b1; l_waddr <= tile_reg;
                        l_wdata <= {sum_reg, len_reg - 1'b1};
                        finish(1'b1, '0, len_reg - 1'b1);
                    end else begin
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    e_we    <= 1'b1;
                    e_waddr <= base_addr | AB'(idx_reg[EB-1:0] - 1'b1);
                    e_wdata <= e_rdata;
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= S_SHIFTW;
                end
                S_MUL: state_reg <= S_MOD;
                S_MOD: begin
                    if (mod_done) begin
                        r_reg <= mod_rem;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK: begin
                    // idx_reg entry was read while waiting; found_reg alternates a wait pass and a step pass per entry
                    if (found_reg) begin
                        found_reg <= 1'b0;
                        acc_reg <= acc_next;
                        if (r_reg < acc_next || idx_reg + 1'b1 >= len_reg) begin
                            finish(1'b1, rd_key, len_reg);
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end else begin
                        found_reg <= 1'b1;
                    end
                end
                S_OUT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
